@@ rtl/core/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

   // window size register
   localparam int                  WS_BITS  = 7;
   localparam logic [WS_BITS-1:0]  WS_RESET = 7'd3;

endpackage

@@ rtl/core/swm_req_if.sv @@
// ----------------------------------------------------------------------------
// swm_req_if
// Sample channel: one sample and its first-of-sequence flag per beat.
// ----------------------------------------------------------------------------
interface swm_req_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          first_of_sequence;

   modport source (output valid, output sample, output first_of_sequence, input ready);
   modport sink   (input valid, input sample, input first_of_sequence, output ready);
endinterface

@@ rtl/core/swm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// swm_rsp_if
// Result channel: one window maximum per beat.
// ----------------------------------------------------------------------------
interface swm_rsp_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

@@ rtl/core/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the maximum chain. Cell k holds the largest of the last k+1
// samples; on each beat it takes the larger of the new sample and the
// value of its left neighbor.
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] left_max,
   output logic signed [SAMPLE_BITS-1:0] cell_max
);

   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic signed [SAMPLE_BITS-1:0] max_in;

   always_comb begin
      max_in = (sample > left_max) ? sample : left_max;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         max_ff <= max_in;
      end
   end

   assign cell_max = max_ff;

endmodule

@@ rtl/core/sliding_window_maximum.sv @@
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Running maximum of the last window_size signed samples of a stream.
//
// req_bus carries one sample per beat with a first_of_sequence flag that
// restarts the stream at that sample. rsp_bus carries one window_max beat
// for every sample once window_size samples of the current stream have
// arrived; earlier samples give no beat. csr_wr_en/csr_wr_data write the
// window size (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX);
// write it only while no beat is in flight.
// A row of WINDOW_MAX-1 cells holds, in cell k, the maximum of the last
// k+1 samples; all cells update together on each accepted sample.
// The result appears on rsp_bus in the cycle after its sample is accepted.
// Throughput: one sample per cycle unless rsp_bus stalls, set by the single
// compare per cell and the cell select into the output register.
// Reset clears the sample count and the output valid, and sets the window
// size to 3. While rsp_bus is stalled the result holds and req_bus.ready
// stays low, so no sample is lost.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   swm_req_if.sink                      req_bus,
   swm_rsp_if.source                    rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [swm_pkg::WS_BITS-1:0]  csr_wr_data
);

   localparam int CELLS     = WINDOW_MAX - 1;
   localparam int IDX_BITS  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SEEN_BITS = $clog2(WINDOW_MAX + 1);
   localparam int CMP_BITS  = (SEEN_BITS > swm_pkg::WS_BITS) ? SEEN_BITS : swm_pkg::WS_BITS;

   logic [swm_pkg::WS_BITS-1:0]   ws_ff;
   logic [SEEN_BITS-1:0]          seen_ff;
   logic [SEEN_BITS-1:0]          seen_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_max_in;

   logic [CMP_BITS-1:0]           ws_wide;
   logic [SEEN_BITS-1:0]          w_eff;
   logic [IDX_BITS-1:0]           sel;
   logic signed [SAMPLE_BITS-1:0] tap;
   logic                          req_fire;
   logic                          emit;

   logic signed [SAMPLE_BITS-1:0] cell_max [CELLS];

   // effective window size
   always_comb begin
      ws_wide = CMP_BITS'(ws_ff);
      if (ws_wide == '0) begin
         w_eff = SEEN_BITS'(1);
      end else if (ws_wide > CMP_BITS'(WINDOW_MAX)) begin
         w_eff = SEEN_BITS'(WINDOW_MAX);
      end else begin
         w_eff = SEEN_BITS'(ws_wide);
      end
   end

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // cell row
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] left;
      if (k == 0) begin : g_head
         assign left = req_bus.sample;
      end else begin : g_body
         assign left = cell_max[k-1];
      end
      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock    (clock),
         .load     (req_fire),
         .sample   (req_bus.sample),
         .left_max (left),
         .cell_max (cell_max[k])
      );
   end

   // window of w samples = new sample plus cell w-2
   always_comb begin
      sel = IDX_BITS'(w_eff - SEEN_BITS'(2));
      tap = cell_max[sel];

      if (req_bus.first_of_sequence) begin
         seen_in = SEEN_BITS'(1);
      end else if (seen_ff >= w_eff) begin
         seen_in = w_eff;
      end else begin
         seen_in = seen_ff + SEEN_BITS'(1);
      end
      emit = (seen_in >= w_eff);

      if (w_eff == SEEN_BITS'(1)) begin
         rsp_max_in = req_bus.sample;
      end else begin
         rsp_max_in = (req_bus.sample > tap) ? req_bus.sample : tap;
      end

      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff        <= swm_pkg::WS_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ws_ff <= csr_wr_data;
         end
         if (req_fire) begin
            seen_ff <= seen_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_max_ff <= rsp_max_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.window_max = rsp_max_ff;

`ifndef ASSERT_OFF
   a_seen_bounded : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> seen_ff <= $past(w_eff))
      else $error("sample count above window size");

   a_restart_count : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.first_of_sequence |=> seen_ff == SEEN_BITS'(1))
      else $error("restart did not reset sample count");

   a_unit_window : assert property (@(posedge clock) disable iff (reset)
      req_fire && w_eff == SEEN_BITS'(1)
      |=> rsp_valid_ff && rsp_max_ff == $past(req_bus.sample))
      else $error("unit window result differs from sample");

   a_valid_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire))
      else $error("result beat without accepted sample");
`endif

endmodule
